/* rtl/bgc_pkg.sv */
// ----------------------------------------------------------------------------
// bgc_pkg
// Shared types, constants and helpers of the gain curve evaluator.
// ----------------------------------------------------------------------------
package bgc_pkg;

  // Gain values are signed Q2.16.
  localparam int YW   = 18;
  // Width of a gain plus a clamped quotient, before saturation.
  localparam int SUMW = YW + 3;

  localparam logic signed [SUMW-1:0] Y_MAX = SUMW'((1 << (YW - 1)) - 1);
  localparam logic signed [SUMW-1:0] Y_MIN = -SUMW'(1 << (YW - 1));

  typedef enum logic [2:0] {
    CFG_START_X = 3'd0,
    CFG_START_Y = 3'd1,
    CFG_MID_X   = 3'd2,
    CFG_MID_Y   = 3'd3,
    CFG_END_X   = 3'd4,
    CFG_END_Y   = 3'd5
  } cfg_idx_t;

  function automatic logic signed [YW-1:0] sat_y(input logic signed [SUMW-1:0] v);
    logic signed [YW-1:0] r;
    if (v > Y_MAX) begin
      r = YW'(Y_MAX);
    end else if (v < Y_MIN) begin
      r = YW'(Y_MIN);
    end else begin
      r = YW'(v);
    end
    return r;
  endfunction

endpackage

/* rtl/bgc_div_cell.sv */
// ----------------------------------------------------------------------------
// bgc_div_cell
// One restoring division step: decides one quotient bit and hands the
// partial remainder, divisor and sideband to the next cell.
// ----------------------------------------------------------------------------
module bgc_div_cell #(
  parameter int NW    = 8,
  parameter int DW    = 8,
  parameter int QW    = 8,
  parameter int SW    = 1,
  parameter int SHIFT = 0
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          valid_i,
  input  logic [NW-1:0] rem_i,
  input  logic [DW-1:0] den_i,
  input  logic [QW-1:0] quo_i,
  input  logic [SW-1:0] side_i,
  output logic          valid_o,
  output logic [NW-1:0] rem_o,
  output logic [DW-1:0] den_o,
  output logic [QW-1:0] quo_o,
  output logic [SW-1:0] side_o
);

  localparam int CW = (NW > DW + SHIFT + 1) ? NW : DW + SHIFT + 1;

  logic [CW-1:0] dsh;
  logic          ge;
  logic          valid_r;
  logic [NW-1:0] rem_r;
  logic [DW-1:0] den_r;
  logic [QW-1:0] quo_r;
  logic [SW-1:0] side_r;

  always_comb begin
    dsh = CW'(den_i) << SHIFT;
    ge  = (CW'(rem_i) >= dsh);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    rem_r  <= ge ? NW'(CW'(rem_i) - dsh) : rem_i;
    den_r  <= den_i;
    quo_r  <= {quo_i[QW-2:0], ge};
    side_r <= side_i;
  end

  assign valid_o = valid_r;
  assign rem_o   = rem_r;
  assign den_o   = den_r;
  assign quo_o   = quo_r;
  assign side_o  = side_r;

endmodule

/* rtl/bgc_divider.sv */
// ----------------------------------------------------------------------------
// bgc_divider
// Pipelined unsigned divider built as a row of restoring cells, one quotient
// bit per cell. The caller guarantees num < den * 2^QW.
// ----------------------------------------------------------------------------
module bgc_divider #(
  parameter int NW = 8,
  parameter int DW = 8,
  parameter int QW = 8,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          valid_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  input  logic [SW-1:0] side_i,
  output logic          valid_o,
  output logic [QW-1:0] quo_o,
  output logic [SW-1:0] side_o
);

  logic          valid_c [0:QW];
  logic [NW-1:0] rem_c   [0:QW];
  logic [DW-1:0] den_c   [0:QW];
  logic [QW-1:0] quo_c   [0:QW];
  logic [SW-1:0] side_c  [0:QW];

  assign valid_c[0] = valid_i;
  assign rem_c[0]   = num_i;
  assign den_c[0]   = den_i;
  assign quo_c[0]   = '0;
  assign side_c[0]  = side_i;

  for (genvar k = 0; k < QW; k++) begin : g_cell
    bgc_div_cell #(
      .NW(NW), .DW(DW), .QW(QW), .SW(SW), .SHIFT(QW - 1 - k)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .valid_i(valid_c[k]),
      .rem_i  (rem_c[k]),
      .den_i  (den_c[k]),
      .quo_i  (quo_c[k]),
      .side_i (side_c[k]),
      .valid_o(valid_c[k+1]),
      .rem_o  (rem_c[k+1]),
      .den_o  (den_c[k+1]),
      .quo_o  (quo_c[k+1]),
      .side_o (side_c[k+1])
    );
  end

  assign valid_o = valid_c[QW];
  assign quo_o   = quo_c[QW];
  assign side_o  = side_c[QW];

endmodule

/* rtl/bezier_gain_curve_eval_unit.sv */
// ----------------------------------------------------------------------------
// bezier_gain_curve_eval_unit
// Gain curve from three control points: two x-keyed interpolations give
// points AB and BC, a third reads the line between them at the sample index.
// ----------------------------------------------------------------------------
// The pipeline runs through stages 0 to 9, three chains of division cells in
// series (one quotient bit per cell) and the stage 10 result register.
// Throughput: one request per cycle; busy is never raised.
// Results appear on out_* with out_valid for one cycle; the receiver cannot stall.
// Synchronous active-low reset empties the pipeline and restores the
// control point registers to their reset values.
module bezier_gain_curve_eval_unit
  import bgc_pkg::*;
#(
  parameter int X_WIDTH   = 20,
  parameter int FRAC_BITS = 16
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     start,
  output logic                                     busy,
  input  logic [X_WIDTH-1:0]                       in_sample_index,
  output logic                                     out_valid,
  output logic signed [YW-1:0]                     out_gain_value,
  output logic                                     out_divide_error,
  input  logic                                     cfg_valid,
  output logic                                     cfg_ready,
  input  logic [2:0]                               cfg_index,
  input  logic [((X_WIDTH > YW) ? X_WIDTH : YW)-1:0] cfg_data
);

  localparam int XW   = X_WIDTH;
  localparam int FB   = FRAC_BITS;
  localparam int XF   = XW + FB;
  localparam int PAW  = 2 * XW;
  localparam int NA   = PAW + FB;
  localparam int XABW = XF + 1;
  localparam int XBW  = XF + 3;
  localparam int DXW  = XF + 4;
  localparam int DYW  = YW + 1;
  localparam int PW   = DXW + DYW;
  localparam int NB   = PW - FB;
  localparam int QB   = YW + 1;
  localparam int OVB  = NB + XW + QB;
  localparam int OVC  = PW + QB;
  localparam int LAT  = 11 + XF + 2 * QB;

  localparam logic [XABW-1:0]        LIM   = XABW'(1) << XF;
  localparam logic signed [XBW-1:0]  LIM_S = XBW'(1) << XF;

  // Control point registers
  logic [XW-1:0]        start_x_r, mid_x_r, end_x_r;
  logic signed [YW-1:0] start_y_r, mid_y_r, end_y_r;

  assign cfg_ready = 1'b1;
  assign busy      = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_x_r <= '0;
      start_y_r <= YW'(65536);
      mid_x_r   <= XW'(512);
      mid_y_r   <= '0;
      end_x_r   <= XW'(1024);
      end_y_r   <= YW'(65536);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_START_X: start_x_r <= cfg_data[XW-1:0];
        CFG_START_Y: start_y_r <= cfg_data[YW-1:0];
        CFG_MID_X:   mid_x_r   <= cfg_data[XW-1:0];
        CFG_MID_Y:   mid_y_r   <= cfg_data[YW-1:0];
        CFG_END_X:   end_x_r   <= cfg_data[XW-1:0];
        CFG_END_Y:   end_y_r   <= cfg_data[YW-1:0];
        default: ;
      endcase
    end
  end

  // Differences of the control points; the user must keep config stable while requests fly (not enforced here).
  logic signed [XW:0] d32, d21;
  logic               d32_neg, d21_neg;
  logic [XW-1:0]      d32_mag, d21_mag;
  logic signed [DYW-1:0] dy21, dy32;
  logic               cfg_err;

  always_comb begin
    d32     = $signed({1'b0, end_x_r}) - $signed({1'b0, mid_x_r});
    d21     = $signed({1'b0, mid_x_r}) - $signed({1'b0, start_x_r});
    d32_neg = d32[XW];
    d21_neg = d21[XW];
    d32_mag = d32_neg ? XW'(-d32) : XW'(d32);
    d21_mag = d21_neg ? XW'(-d21) : XW'(d21);
    dy21    = DYW'(mid_y_r) - DYW'(start_y_r);
    dy32    = DYW'(end_y_r) - DYW'(mid_y_r);
    cfg_err = (end_x_r == '0) || (mid_x_r == start_x_r) || (end_x_r == mid_x_r);
  end

  // Stage 0: capture request
  logic          s0_valid_r;
  logic [XW-1:0] s0_n_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
    end else begin
      s0_valid_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    s0_n_r <= in_sample_index;
  end

  // Stage 1: numerators of the two scaled positions
  logic           s1_valid_r;
  logic [XW-1:0]  s1_n_r;
  logic [PAW-1:0] s1_pab_r, s1_pst_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s0_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_n_r   <= s0_n_r;
    s1_pab_r <= PAW'(s0_n_r) * PAW'(mid_x_r);
    s1_pst_r <= PAW'(s0_n_r) * PAW'(d32_mag);
  end

  // Stage 2: overflow check, feeds the position dividers
  logic          s2_valid_r;
  logic [XW-1:0] s2_n_r;
  logic [NA-1:0] s2_num_ab_r, s2_num_st_r;
  logic          s2_ov_ab_r, s2_ov_st_r;
  logic [PAW-1:0] ex_lim;

  assign ex_lim = PAW'(end_x_r) << XW;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    s2_n_r      <= s1_n_r;
    s2_num_ab_r <= {s1_pab_r, {FB{1'b0}}};
    s2_num_st_r <= {s1_pst_r, {FB{1'b0}}};
    s2_ov_ab_r  <= (s1_pab_r >= ex_lim);
    s2_ov_st_r  <= (s1_pst_r >= ex_lim);
  end

  logic          da_valid, db_valid;
  logic [XF-1:0] da_q, db_q;
  logic [XW:0]   da_side;
  logic          db_side;

  bgc_divider #(.NW(NA), .DW(XW), .QW(XF), .SW(XW + 1)) u_div_ab (
    .clk    (clk),
    .rst_n  (rst_n),
    .valid_i(s2_valid_r),
    .num_i  (s2_num_ab_r),
    .den_i  (end_x_r),
    .side_i ({s2_n_r, s2_ov_ab_r}),
    .valid_o(da_valid),
    .quo_o  (da_q),
    .side_o (da_side)
  );

  bgc_divider #(.NW(NA), .DW(XW), .QW(XF), .SW(1)) u_div_st (
    .clk    (clk),
    .rst_n  (rst_n),
    .valid_i(s2_valid_r),
    .num_i  (s2_num_st_r),
    .den_i  (end_x_r),
    .side_i (s2_ov_st_r),
    .valid_o(db_valid),
    .quo_o  (db_q),
    .side_o (db_side)
  );

  // Stage 3: x of AB and BC
  logic                  s3_valid_r;
  logic [XW-1:0]         s3_n_r;
  logic [XABW-1:0]       s3_xab_r;
  logic signed [XBW-1:0] s3_xbc_r;
  logic [XABW-1:0]       xab_c, step_c;
  logic signed [XBW-1:0] xbc_raw, xbc_c;

  always_comb begin
    xab_c   = da_side[0] ? LIM : {1'b0, da_q};
    step_c  = db_side ? LIM : {1'b0, db_q};
    xbc_raw = d32_neg ? $signed({3'b000, mid_x_r, {FB{1'b0}}}) - $signed({2'b00, step_c})
                      : $signed({3'b000, mid_x_r, {FB{1'b0}}}) + $signed({2'b00, step_c});
    if (xbc_raw > LIM_S) begin
      xbc_c = LIM_S;
    end else if (xbc_raw < -LIM_S) begin
      xbc_c = -LIM_S;
    end else begin
      xbc_c = xbc_raw;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
    end else begin
      s3_valid_r <= da_valid && db_valid;
    end
  end

  always_ff @(posedge clk) begin
    s3_n_r   <= da_side[XW:1];
    s3_xab_r <= xab_c;
    s3_xbc_r <= xbc_c;
  end

  // Stage 4: x offsets of the three interpolations
  logic                  s4_valid_r;
  logic signed [DXW-1:0] s4_dxn_ab_r, s4_dxn_bc_r, s4_dxn_f_r, s4_dxo_r;
  logic signed [DXW-1:0] xab_e, xbc_e;

  always_comb begin
    xab_e = $signed({3'b000, s3_xab_r});
    xbc_e = DXW'(s3_xbc_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_valid_r <= 1'b0;
    end else begin
      s4_valid_r <= s3_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    s4_dxn_ab_r <= xab_e - $signed({4'b0000, start_x_r, {FB{1'b0}}});
    s4_dxn_bc_r <= xbc_e - $signed({4'b0000, mid_x_r, {FB{1'b0}}});
    s4_dxn_f_r  <= $signed({4'b0000, s3_n_r, {FB{1'b0}}}) - xab_e;
    s4_dxo_r    <= xbc_e - xab_e;
  end

  // Stage 5: products for AB and BC
  logic                  s5_valid_r;
  logic signed [PW-1:0]  s5_p_ab_r, s5_p_bc_r;
  logic signed [DXW-1:0] s5_dxn_f_r, s5_dxo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_valid_r <= 1'b0;
    end else begin
      s5_valid_r <= s4_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    s5_p_ab_r  <= PW'(s4_dxn_ab_r) * PW'(dy21);
    s5_p_bc_r  <= PW'(s4_dxn_bc_r) * PW'(dy32);
    s5_dxn_f_r <= s4_dxn_f_r;
    s5_dxo_r   <= s4_dxo_r;
  end

  // Stage 6: sign and magnitude for the AB and BC dividers. The divisor is
  // a whole sample count, so the fraction bits of the product drop first.
  logic                  s6_valid_r;
  logic [NB-1:0]         s6_num_ab_r, s6_num_bc_r;
  logic                  s6_sign_ab_r, s6_sign_bc_r, s6_ov_ab_r, s6_ov_bc_r;
  logic signed [DXW-1:0] s6_dxn_f_r, s6_dxo_r;
  logic [PW-1:0]         mag_ab, mag_bc;

  always_comb begin
    mag_ab = s5_p_ab_r[PW-1] ? PW'(-s5_p_ab_r) : PW'(s5_p_ab_r);
    mag_bc = s5_p_bc_r[PW-1] ? PW'(-s5_p_bc_r) : PW'(s5_p_bc_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s6_valid_r <= 1'b0;
    end else begin
      s6_valid_r <= s5_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    s6_num_ab_r  <= mag_ab[PW-1:FB];
    s6_num_bc_r  <= mag_bc[PW-1:FB];
    s6_sign_ab_r <= s5_p_ab_r[PW-1] ^ d21_neg;
    s6_sign_bc_r <= s5_p_bc_r[PW-1] ^ d32_neg;
    s6_ov_ab_r   <= (OVB'(mag_ab[PW-1:FB]) >= (OVB'(d21_mag) << QB));
    s6_ov_bc_r   <= (OVB'(mag_bc[PW-1:FB]) >= (OVB'(d32_mag) << QB));
    s6_dxn_f_r   <= s5_dxn_f_r;
    s6_dxo_r     <= s5_dxo_r;
  end

  logic                  dc_valid, dd_valid;
  logic [QB-1:0]         dc_q, dd_q;
  logic [2*DXW+1:0]      dc_side;
  logic [1:0]            dd_side;

  bgc_divider #(.NW(NB), .DW(XW), .QW(QB), .SW(2 * DXW + 2)) u_div_yab (
    .clk    (clk),
    .rst_n  (rst_n),
    .valid_i(s6_valid_r),
    .num_i  (s6_num_ab_r),
    .den_i  (d21_mag),
    .side_i ({s6_dxn_f_r, s6_dxo_r, s6_sign_ab_r, s6_ov_ab_r}),
    .valid_o(dc_valid),
    .quo_o  (dc_q),
    .side_o (dc_side)
  );

  bgc_divider #(.NW(NB), .DW(XW), .QW(QB), .SW(2)) u_div_ybc (
    .clk    (clk),
    .rst_n  (rst_n),
    .valid_i(s6_valid_r),
    .num_i  (s6_num_bc_r),
    .den_i  (d32_mag),
    .side_i ({s6_sign_bc_r, s6_ov_bc_r}),
    .valid_o(dd_valid),
    .quo_o  (dd_q),
    .side_o (dd_side)
  );

  // Stage 7: y of AB and BC
  logic                  s7_valid_r;
  logic signed [YW-1:0]  s7_yab_r, s7_ybc_r;
  logic signed [DXW-1:0] s7_dxn_f_r, s7_dxo_r;
  logic [QB-1:0]         qab, qbc;
  logic signed [SUMW-1:0] sum_ab, sum_bc;

  always_comb begin
    // A clamped quotient of all ones is already far past the gain range.
    qab    = dc_side[0] ? '1 : dc_q;
    qbc    = dd_side[0] ? '1 : dd_q;
    sum_ab = dc_side[1] ? SUMW'(start_y_r) - $signed(SUMW'(qab))
                        : SUMW'(start_y_r) + $signed(SUMW'(qab));
    sum_bc = dd_side[1] ? SUMW'(mid_y_r) - $signed(SUMW'(qbc))
                        : SUMW'(mid_y_r) + $signed(SUMW'(qbc));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s7_valid_r <= 1'b0;
    end else begin
      s7_valid_r <= dc_valid && dd_valid;
    end
  end

  always_ff @(posedge clk) begin
    s7_yab_r   <= sat_y(sum_ab);
    s7_ybc_r   <= sat_y(sum_bc);
    s7_dxn_f_r <= dc_side[2*DXW+1:DXW+2];
    s7_dxo_r   <= dc_side[DXW+1:2];
  end

  // Stage 8: product of the final interpolation
  logic                  s8_valid_r;
  logic signed [PW-1:0]  s8_p_r;
  logic signed [DXW-1:0] s8_dxo_r;
  logic signed [YW-1:0]  s8_yab_r;
  logic signed [DYW-1:0] dy_f;

  assign dy_f = DYW'(s7_ybc_r) - DYW'(s7_yab_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s8_valid_r <= 1'b0;
    end else begin
      s8_valid_r <= s7_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    s8_p_r   <= PW'(s7_dxn_f_r) * PW'(dy_f);
    s8_dxo_r <= s7_dxo_r;
    s8_yab_r <= s7_yab_r;
  end

  // Stage 9: sign and magnitude for the final divider
  logic                 s9_valid_r;
  logic [PW-1:0]        s9_num_r;
  logic [DXW-1:0]       s9_den_r;
  logic signed [YW-1:0] s9_yab_r;
  logic                 s9_sign_r, s9_ov_r, s9_dz_r;
  logic [PW-1:0]        mag_f;
  logic [DXW-1:0]       mag_dxo;

  always_comb begin
    mag_f   = s8_p_r[PW-1] ? PW'(-s8_p_r) : PW'(s8_p_r);
    mag_dxo = s8_dxo_r[DXW-1] ? DXW'(-s8_dxo_r) : DXW'(s8_dxo_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s9_valid_r <= 1'b0;
    end else begin
      s9_valid_r <= s8_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    s9_num_r  <= mag_f;
    s9_den_r  <= mag_dxo;
    s9_yab_r  <= s8_yab_r;
    s9_sign_r <= s8_p_r[PW-1] ^ s8_dxo_r[DXW-1];
    s9_ov_r   <= (OVC'(mag_f) >= (OVC'(mag_dxo) << QB));
    s9_dz_r   <= (s8_dxo_r == '0);
  end

  logic          de_valid;
  logic [QB-1:0] de_q;
  logic [YW+2:0] de_side;

  bgc_divider #(.NW(PW), .DW(DXW), .QW(QB), .SW(YW + 3)) u_div_y (
    .clk    (clk),
    .rst_n  (rst_n),
    .valid_i(s9_valid_r),
    .num_i  (s9_num_r),
    .den_i  (s9_den_r),
    .side_i ({s9_yab_r, s9_sign_r, s9_ov_r, s9_dz_r}),
    .valid_o(de_valid),
    .quo_o  (de_q),
    .side_o (de_side)
  );

  // Stage 10: result register
  logic                   out_valid_r, out_err_r;
  logic signed [YW-1:0]   out_gain_r;
  logic [QB-1:0]          qf;
  logic signed [SUMW-1:0] sum_f;
  logic                   err_f;

  always_comb begin
    qf    = de_side[1] ? '1 : de_q;
    sum_f = de_side[2] ? SUMW'($signed(de_side[YW+2:3])) - $signed(SUMW'(qf))
                       : SUMW'($signed(de_side[YW+2:3])) + $signed(SUMW'(qf));
    err_f = cfg_err || de_side[0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= de_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_err_r  <= err_f;
    out_gain_r <= err_f ? start_y_r : sat_y(sum_f);
  end

  assign out_valid        = out_valid_r;
  assign out_gain_value   = out_gain_r;
  assign out_divide_error = out_err_r;

  // Every accepted request must produce a result on out_valid.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##LAT out_valid)
    else $error("request did not produce a result on time");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start, LAT))
    else $error("result without a matching request");

  a_xab_range: assert property (@(posedge clk) disable iff (!rst_n)
    s3_valid_r |-> (s3_xab_r <= LIM))
    else $error("AB position beyond its limit");

  a_lanes_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    (da_valid == db_valid) && (dc_valid == dd_valid))
    else $error("parallel divider lanes out of step");

endmodule
